/* hdl/rimf_pkg.sv */
// ----------------------------------------------------------------------------
// rimf_pkg
// Shared widths, opcodes, read-step codes and the controller command struct
// of the two-replica Ising Metropolis flip core.
// ----------------------------------------------------------------------------
`default_nettype none

package rimf_pkg;

    // Lattice side; must be a power of two so row/column wrap is a plain
    // modular add on ADDR_W bits.
    localparam int SIDE        = 8;
    localparam int ADDR_W      = $clog2(SIDE);
    localparam int CELL_W      = 2 * ADDR_W;
    localparam int CELLS       = SIDE * SIDE;

    localparam int CMD_W       = 2;
    localparam int BOND_BITS   = 8;
    localparam int ENERGY_BITS = 21;
    localparam int THRESH_W    = 20;
    localparam int DE_OUT_W    = 12;

    // Four bond terms plus room for negation.
    localparam int ACC_W       = BOND_BITS + 3;
    // Own layer plus other layer.
    localparam int SUM_W       = ACC_W + 1;
    // Times -2.
    localparam int DE_W        = SUM_W + 1;
    // Signed compare against the unsigned threshold.
    localparam int CMP_W       = THRESH_W + 1;

    localparam logic [CMD_W-1:0] CMD_LOAD_BONDS = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_SPIN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_ENERGY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TRIAL      = 2'd3;

    // Memory read sequence of one trial.
    typedef enum logic [2:0] {
        STEP_CENTER,
        STEP_UP,
        STEP_DOWN,
        STEP_LEFT,
        STEP_RIGHT
    } step_t;

    typedef struct packed {
        logic  latch;       // capture the input beat
        logic  issue_en;    // read memories at issue_step address
        step_t issue_step;
        logic  acc_en;      // fold the read data of acc_step
        step_t acc_step;
        logic  eval_en;     // form dE
        logic  emit;        // write state, load output register
    } rimf_cmd_t;

endpackage

`default_nettype wire

/* hdl/rimf_ctrl.sv */
// ----------------------------------------------------------------------------
// rimf_ctrl
// Sequencer of the flip core: input handshake, the read sequence of a trial
// and the output register's valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rimf_ctrl
    import rimf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [CMD_W-1:0] cmd,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output rimf_cmd_t        ctl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ISSUE,
        ST_DRAIN,
        ST_EVAL,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        ctl            = '0;
        ctl.issue_step = step_reg;
        ctl.acc_step   = STEP_CENTER;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.latch = 1'b1;
                    if (cmd == CMD_TRIAL)
                    begin
                        state_next = ST_ISSUE;
                        step_next  = STEP_CENTER;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_ISSUE:
            begin
                ctl.issue_en = 1'b1;
                if (step_reg != STEP_CENTER)
                begin
                    ctl.acc_en   = 1'b1;
                    ctl.acc_step = step_t'(step_reg - 3'd1);
                end
                if (step_reg == STEP_RIGHT)
                    state_next = ST_DRAIN;
                else
                    step_next = step_t'(step_reg + 3'd1);
            end
            ST_DRAIN:
            begin
                ctl.acc_en   = 1'b1;
                ctl.acc_step = STEP_RIGHT;
                state_next   = ST_EVAL;
            end
            ST_EVAL:
            begin
                ctl.eval_en = 1'b1;
                state_next  = ST_COMMIT;
            end
            ST_LOAD, ST_COMMIT:
            begin
                if (out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = ctl.emit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_CENTER;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/rimf_datapath.sv */
// ----------------------------------------------------------------------------
// rimf_datapath
// Spin and bond memories, neighbour accumulation, dE, acceptance test,
// saturating energy total and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rimf_datapath
    import rimf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  rimf_cmd_t                  ctl,
    input  logic [CMD_W-1:0]           cmd,
    input  logic                       layer,
    input  logic [ADDR_W-1:0]          site_row,
    input  logic [ADDR_W-1:0]          site_col,
    input  logic signed [BOND_BITS-1:0] bond_down,
    input  logic signed [BOND_BITS-1:0] bond_right,
    input  logic                       spin_up,
    input  logic signed [ENERGY_BITS-1:0] energy_load,
    input  logic [THRESH_W-1:0]        accept_threshold,
    output logic                       accepted,
    output logic signed [DE_OUT_W-1:0] energy_change,
    output logic signed [ENERGY_BITS-1:0] energy_total
);

    localparam logic [ADDR_W-1:0] HALF_ROW = ADDR_W'(SIDE / 2);
    localparam logic signed [ENERGY_BITS-1:0] E_MAX = {1'b0, {(ENERGY_BITS-1){1'b1}}};
    localparam logic signed [ENERGY_BITS-1:0] E_MIN = {1'b1, {(ENERGY_BITS-1){1'b0}}};
    localparam logic signed [DE_OUT_W-1:0] DE_OUT_MAX = {1'b0, {(DE_OUT_W-1){1'b1}}};
    localparam logic signed [DE_OUT_W-1:0] DE_OUT_MIN = {1'b1, {(DE_OUT_W-1){1'b0}}};

    // latched beat
    logic [CMD_W-1:0]              op_reg;
    logic                          layer_reg;
    logic [ADDR_W-1:0]             row_reg, col_reg;
    logic [BOND_BITS-1:0]          bond_v_reg, bond_h_reg;
    logic                          spin_reg;
    logic signed [ENERGY_BITS-1:0] eload_reg;
    logic [THRESH_W-1:0]           thresh_reg;

    // memories
    logic                   spin_first_mem  [CELLS];
    logic                   spin_second_mem [CELLS];
    logic [2*BOND_BITS-1:0] bond_mem        [CELLS];   // {vertical, horizontal}

    logic                   first_rd_reg, second_rd_reg;
    logic [2*BOND_BITS-1:0] bond_rd_reg;

    logic [ADDR_W-1:0] row_up, row_dn, col_lf, col_rt;
    logic [ADDR_W-1:0] srow, scol, brow, bcol;
    logic [CELL_W-1:0] cell_addr;
    logic              shared;

    // accumulation
    logic signed [BOND_BITS-1:0] bond_sel;
    logic signed [ACC_W-1:0]     bond_ext, term_first, term_second;
    logic signed [ACC_W-1:0]     acc_first_reg, acc_second_reg;
    logic                        s_first_reg, s_second_reg;

    // dE
    logic signed [ACC_W-1:0] nn_first, nn_second, nn_own, nn_other;
    logic signed [SUM_W-1:0] nn_sum;
    logic signed [DE_W-1:0]  de_next, de_reg;

    // commit
    logic signed [CMP_W-1:0]         de_cmp, thresh_cmp;
    logic                            trial_ok, is_trial;
    logic signed [ENERGY_BITS:0]     energy_sum;
    logic signed [ENERGY_BITS-1:0]   energy_sat;
    logic signed [ENERGY_BITS-1:0]   energy_acc_reg, energy_acc_next;
    logic signed [DE_OUT_W-1:0]      de_out;
    logic                            first_we, second_we, bond_we;
    logic                            first_wd, second_wd;
    logic                            hit_first, hit_second;

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            op_reg     <= cmd;
            layer_reg  <= layer;
            row_reg    <= site_row;
            col_reg    <= site_col;
            bond_v_reg <= bond_down;
            bond_h_reg <= bond_right;
            spin_reg   <= spin_up;
            eload_reg  <= energy_load;
            thresh_reg <= accept_threshold;
        end
    end

    // Periodic wrap falls out of ADDR_W-bit arithmetic.
    assign row_up    = row_reg - 1'b1;
    assign row_dn    = row_reg + 1'b1;
    assign col_lf    = col_reg - 1'b1;
    assign col_rt    = col_reg + 1'b1;
    assign cell_addr = {row_reg, col_reg};
    assign shared    = (row_reg >= HALF_ROW);

    always_comb
    begin
        srow = row_reg;
        scol = col_reg;
        brow = row_reg;
        bcol = col_reg;
        unique case (ctl.issue_step)
            STEP_UP:
            begin
                srow = row_up;
                brow = row_up;
            end
            STEP_DOWN:
            begin
                srow = row_dn;
            end
            STEP_LEFT:
            begin
                scol = col_lf;
                bcol = col_lf;
            end
            STEP_RIGHT:
            begin
                scol = col_rt;
            end
            default:
            begin
                srow = row_reg;
            end
        endcase
    end

    // write side
    assign is_trial   = (op_reg == CMD_TRIAL);
    assign hit_first  = !layer_reg || shared;
    assign hit_second = layer_reg || shared;
    assign first_we   = ctl.emit && hit_first &&
                        ((op_reg == CMD_LOAD_SPIN) || (is_trial && trial_ok));
    assign second_we  = ctl.emit && hit_second &&
                        ((op_reg == CMD_LOAD_SPIN) || (is_trial && trial_ok));
    assign first_wd   = (op_reg == CMD_LOAD_SPIN) ? spin_reg : !s_first_reg;
    assign second_wd  = (op_reg == CMD_LOAD_SPIN) ? spin_reg : !s_second_reg;
    assign bond_we    = ctl.emit && (op_reg == CMD_LOAD_BONDS);

    always_ff @(posedge clk)
    begin
        if (first_we)
            spin_first_mem[cell_addr] <= first_wd;
        if (ctl.issue_en)
            first_rd_reg <= spin_first_mem[{srow, scol}];
    end

    always_ff @(posedge clk)
    begin
        if (second_we)
            spin_second_mem[cell_addr] <= second_wd;
        if (ctl.issue_en)
            second_rd_reg <= spin_second_mem[{srow, scol}];
    end

    always_ff @(posedge clk)
    begin
        if (bond_we)
            bond_mem[cell_addr] <= {bond_v_reg, bond_h_reg};
        if (ctl.issue_en)
            bond_rd_reg <= bond_mem[{brow, bcol}];
    end

    // Up/down steps use the vertical bond, left/right the horizontal one.
    assign bond_sel = ((ctl.acc_step == STEP_UP) || (ctl.acc_step == STEP_DOWN))
                      ? bond_rd_reg[2*BOND_BITS-1:BOND_BITS]
                      : bond_rd_reg[BOND_BITS-1:0];
    assign bond_ext    = ACC_W'(bond_sel);
    assign term_first  = first_rd_reg  ? bond_ext : -bond_ext;
    assign term_second = second_rd_reg ? bond_ext : -bond_ext;

    always_ff @(posedge clk)
    begin
        if (ctl.acc_en)
        begin
            if (ctl.acc_step == STEP_CENTER)
            begin
                s_first_reg  <= first_rd_reg;
                s_second_reg <= second_rd_reg;
            end
            else if (ctl.acc_step == STEP_UP)
            begin
                acc_first_reg  <= term_first;
                acc_second_reg <= term_second;
            end
            else
            begin
                acc_first_reg  <= acc_first_reg + term_first;
                acc_second_reg <= acc_second_reg + term_second;
            end
        end
    end

    // dE = -2 * (own layer + other layer when the row is shared)
    assign nn_first  = s_first_reg  ? acc_first_reg  : -acc_first_reg;
    assign nn_second = s_second_reg ? acc_second_reg : -acc_second_reg;
    assign nn_own    = layer_reg ? nn_second : nn_first;
    assign nn_other  = layer_reg ? nn_first  : nn_second;
    assign nn_sum    = SUM_W'(nn_own) + (shared ? SUM_W'(nn_other) : SUM_W'(0));
    assign de_next   = DE_W'(0) - {nn_sum, 1'b0};

    always_ff @(posedge clk)
    begin
        if (ctl.eval_en)
            de_reg <= de_next;
    end

    // acceptance
    assign de_cmp     = CMP_W'(de_reg);
    assign thresh_cmp = {1'b0, thresh_reg};
    assign trial_ok   = (&thresh_reg) || (de_cmp <= thresh_cmp);

    assign energy_sum = (ENERGY_BITS + 1)'(energy_acc_reg) + (ENERGY_BITS + 1)'(de_reg);
    assign energy_sat = (energy_sum[ENERGY_BITS] != energy_sum[ENERGY_BITS-1])
                        ? (energy_sum[ENERGY_BITS] ? E_MIN : E_MAX)
                        : energy_sum[ENERGY_BITS-1:0];

    assign de_out = (de_reg[DE_W-1] != de_reg[DE_OUT_W-1])
                    ? (de_reg[DE_W-1] ? DE_OUT_MIN : DE_OUT_MAX)
                    : de_reg[DE_OUT_W-1:0];

    always_comb
    begin
        energy_acc_next = energy_acc_reg;
        if (ctl.emit)
        begin
            if (op_reg == CMD_SET_ENERGY)
                energy_acc_next = eload_reg;
            else if (is_trial && trial_ok)
                energy_acc_next = energy_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            energy_acc_reg <= '0;
        else
            energy_acc_reg <= energy_acc_next;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            accepted      <= is_trial && trial_ok;
            energy_change <= is_trial ? de_out : DE_OUT_W'(0);
            energy_total  <= energy_acc_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/replica_ising_metropolis_flip_core.sv */
// ----------------------------------------------------------------------------
// replica_ising_metropolis_flip_core
// Two-replica Metropolis spin-flip unit for an 8x8 periodic Ising lattice.
// ----------------------------------------------------------------------------
// The core holds two spin layers of an 8x8 periodic lattice (rows 4..7 are
// shared by both layers), one pair of signed 8-bit bonds per site (down and
// right) and a 21-bit saturating energy total that resets to zero. Each input
// beat carries one command: load bonds, load spin (both layers in a shared
// row), set energy, or a Metropolis trial. A trial sums bond x neighbour spin
// x site spin over the addressed layer (plus the other layer in a shared
// row), forms dE = -2 x that sum, accepts when dE <= accept_threshold (all
// ones always accepts), flips the spin and adds dE to the energy total. Every
// beat yields exactly one result beat: accepted, energy_change (dE saturated
// to 12 bits, zero for loads) and energy_total after the command. Spins and
// bonds are undefined until loaded; a trial must only touch loaded sites.
// Timing: one beat at a time. A load's result is loaded into the output
// register by the LOAD state, which then returns to idle for the next
// beat. A trial runs ISSUE (five sequential reads, site and four
// neighbors, of the spin and bond memories), DRAIN (fold the last read),
// EVAL (dE formation) and COMMIT (acceptance, write-back and output
// register), then returns to idle. A command that finishes while the
// previous result still waits in the output register holds until that
// beat is taken. in_stall is low whenever the core is idle, also while
// the previous result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module replica_ising_metropolis_flip_core
    import rimf_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,

    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [CMD_W-1:0]              cmd,
    input  logic                          layer,
    input  logic [ADDR_W-1:0]             site_row,
    input  logic [ADDR_W-1:0]             site_col,
    input  logic signed [BOND_BITS-1:0]   bond_down,
    input  logic signed [BOND_BITS-1:0]   bond_right,
    input  logic                          spin_up,
    input  logic signed [ENERGY_BITS-1:0] energy_load,
    input  logic [THRESH_W-1:0]           accept_threshold,

    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          accepted,
    output logic signed [DE_OUT_W-1:0]    energy_change,
    output logic signed [ENERGY_BITS-1:0] energy_total
);

    rimf_cmd_t ctl;

    // sequencer: handshake, trial read sequence, output valid
    rimf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    // memories, dE arithmetic, energy total, output register
    rimf_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .cmd              (cmd),
        .layer            (layer),
        .site_row         (site_row),
        .site_col         (site_col),
        .bond_down        (bond_down),
        .bond_right       (bond_right),
        .spin_up          (spin_up),
        .energy_load      (energy_load),
        .accept_threshold (accept_threshold),
        .accepted         (accepted),
        .energy_change    (energy_change),
        .energy_total     (energy_total)
    );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-replica Ising Metropolis flip core.
// ----------------------------------------------------------------------------
// A queue of lattice commands is built up front. It holds a fill pass that
// writes every bond and spin, a short directed run on the extremes, then about
// 880 random commands, mostly trials. A negedge driver feeds the input
// channel. A posedge process updates a local lattice copy for each taken
// input beat and queues the outcome it predicts. A posedge monitor checks each
// result beat against the oldest queued outcome.
// ----------------------------------------------------------------------------

module testbench;
    import rimf_pkg::*;

    localparam int  E_MAX       = (1 << (ENERGY_BITS - 1)) - 1;
    localparam int  HOLD_CYCLES = 80;      // long receiver hold-off
    localparam int  STALL_PCT   = 29;      // idle rate of either side
    localparam int  WATCHDOG    = 4000;    // cycles with no beat on either side
    localparam int  DRAIN       = 16;      // wait after the last result before the verdict

    typedef struct {
        logic [CMD_W-1:0]              op;
        logic                          lay;
        logic [ADDR_W-1:0]             row;
        logic [ADDR_W-1:0]             col;
        logic signed [BOND_BITS-1:0]   down;
        logic signed [BOND_BITS-1:0]   right;
        logic                          spin;
        logic signed [ENERGY_BITS-1:0] energy;
        logic [THRESH_W-1:0]           thresh;
    } lattice_cmd_t;

    typedef struct {
        logic                          acc;
        logic signed [DE_OUT_W-1:0]    de;
        logic signed [ENERGY_BITS-1:0] total;
    } flip_outcome_t;

    // DUT ports; inputs known from time zero
    logic                          clk              = 1'b0;
    logic                          rst_n            = 1'b0;
    logic                          in_valid         = 1'b0;
    logic                          in_stall;
    logic [CMD_W-1:0]              cmd              = '0;
    logic                          layer            = 1'b0;
    logic [ADDR_W-1:0]             site_row         = '0;
    logic [ADDR_W-1:0]             site_col         = '0;
    logic signed [BOND_BITS-1:0]   bond_down        = '0;
    logic signed [BOND_BITS-1:0]   bond_right       = '0;
    logic                          spin_up          = 1'b0;
    logic signed [ENERGY_BITS-1:0] energy_load      = '0;
    logic [THRESH_W-1:0]           accept_threshold = '0;
    logic                          out_valid;
    logic                          out_stall        = 1'b0;
    logic                          accepted;
    logic signed [DE_OUT_W-1:0]    energy_change;
    logic signed [ENERGY_BITS-1:0] energy_total;

    // Local lattice copy: spins per layer, bonds per site, energy total
    bit                            lattice_spins [2][CELLS];
    logic signed [BOND_BITS-1:0]   bonds_down_at [CELLS];
    logic signed [BOND_BITS-1:0]   bonds_right_at [CELLS];
    longint                        energy_now = 0;

    lattice_cmd_t  lattice_cmds [$];   // commands not yet offered
    flip_outcome_t due_outcomes [$];   // predicted results not yet seen
    lattice_cmd_t  cur_cmd;            // command on the input port now

    int cmds_total    = 0;
    int cmds_offered  = 0;
    int cmds_taken    = 0;
    int outcomes_seen = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    replica_ising_metropolis_flip_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .layer            (layer),
        .site_row         (site_row),
        .site_col         (site_col),
        .bond_down        (bond_down),
        .bond_right       (bond_right),
        .spin_up          (spin_up),
        .energy_load      (energy_load),
        .accept_threshold (accept_threshold),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .accepted         (accepted),
        .energy_change    (energy_change),
        .energy_total     (energy_total)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Lattice predictor
    // ------------------------------------------------------------------------
    function automatic longint clamp_to(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int spin_sign(int lay, int r, int c);
        return lattice_spins[lay][r * SIDE + c] ? 1 : -1;
    endfunction

    // s x sum(bond x neighbour) over one layer, periodic wrap
    function automatic longint site_coupling(int lay, int r, int c);
        int     ru;
        int     rd;
        int     cl;
        int     cr;
        longint sum;
        ru  = (r + SIDE - 1) % SIDE;
        rd  = (r + 1) % SIDE;
        cl  = (c + SIDE - 1) % SIDE;
        cr  = (c + 1) % SIDE;
        sum = longint'(bonds_down_at[ru * SIDE + c])  * spin_sign(lay, ru, c)
            + longint'(bonds_down_at[r * SIDE + c])   * spin_sign(lay, rd, c)
            + longint'(bonds_right_at[r * SIDE + cl]) * spin_sign(lay, r, cl)
            + longint'(bonds_right_at[r * SIDE + c])  * spin_sign(lay, r, cr);
        return sum * spin_sign(lay, r, c);
    endfunction

    // Applies one command to the lattice copy and returns its result beat.
    function automatic flip_outcome_t apply_lattice_cmd(lattice_cmd_t b);
        int            r;
        int            c;
        int            idx;
        bit            shared;
        longint        de;
        flip_outcome_t o;
        r      = int'(b.row);
        c      = int'(b.col);
        idx    = r * SIDE + c;
        shared = (r >= SIDE / 2);
        de     = 0;
        o.acc  = 1'b0;
        case (b.op)
            CMD_LOAD_BONDS:
            begin
                bonds_down_at[idx]  = b.down;
                bonds_right_at[idx] = b.right;
            end
            CMD_LOAD_SPIN:
            begin
                // shared rows hold one spin for both layers
                if (!b.lay || shared) lattice_spins[0][idx] = b.spin;
                if (b.lay || shared) lattice_spins[1][idx] = b.spin;
            end
            CMD_SET_ENERGY:
            begin
                energy_now = longint'(b.energy);
            end
            default:
            begin
                de = -2 * site_coupling(int'(b.lay), r, c);
                if (shared)
                    de += -2 * site_coupling(int'(!b.lay), r, c);
                // all-ones threshold always accepts; full dE used for compare
                if (b.thresh == '1 || de <= longint'(b.thresh))
                begin
                    o.acc = 1'b1;
                    if (!b.lay || shared) lattice_spins[0][idx] ^= 1'b1;
                    if (b.lay || shared) lattice_spins[1][idx] ^= 1'b1;
                    energy_now = clamp_to(energy_now + de, -E_MAX - 1, E_MAX);
                end
            end
        endcase
        o.de    = DE_OUT_W'(clamp_to(de, -2048, 2047));
        o.total = ENERGY_BITS'(energy_now);
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Command builders: unused fields carry random noise
    // ------------------------------------------------------------------------
    function automatic lattice_cmd_t noise_cmd(logic [CMD_W-1:0] op);
        lattice_cmd_t b;
        b.op     = op;
        b.lay    = 1'($urandom);
        b.row    = ADDR_W'($urandom);
        b.col    = ADDR_W'($urandom);
        b.down   = BOND_BITS'($urandom);
        b.right  = BOND_BITS'($urandom);
        b.spin   = 1'($urandom);
        b.energy = ENERGY_BITS'($urandom);
        b.thresh = THRESH_W'($urandom);
        return b;
    endfunction

    function automatic void push_bonds(int r, int c, int d, int rt);
        lattice_cmd_t b;
        b       = noise_cmd(CMD_LOAD_BONDS);
        b.row   = ADDR_W'(r);
        b.col   = ADDR_W'(c);
        b.down  = BOND_BITS'(d);
        b.right = BOND_BITS'(rt);
        lattice_cmds.push_back(b);
    endfunction

    function automatic void push_spin(int lay, int r, int c, int s);
        lattice_cmd_t b;
        b      = noise_cmd(CMD_LOAD_SPIN);
        b.lay  = 1'(lay);
        b.row  = ADDR_W'(r);
        b.col  = ADDR_W'(c);
        b.spin = 1'(s);
        lattice_cmds.push_back(b);
    endfunction

    function automatic void push_energy(int e);
        lattice_cmd_t b;
        b        = noise_cmd(CMD_SET_ENERGY);
        b.energy = ENERGY_BITS'(e);
        lattice_cmds.push_back(b);
    endfunction

    function automatic void push_trial(int lay, int r, int c, int th);
        lattice_cmd_t b;
        b        = noise_cmd(CMD_TRIAL);
        b.lay    = 1'(lay);
        b.row    = ADDR_W'(r);
        b.col    = ADDR_W'(c);
        b.thresh = THRESH_W'(th);
        lattice_cmds.push_back(b);
    endfunction

    // dE spans about +-2048: keep most thresholds in that band
    function automatic logic [THRESH_W-1:0] pick_threshold();
        int p;
        p = $urandom_range(0, 99);
        if (p < 25) return '0;
        if (p < 65) return THRESH_W'($urandom_range(0, 700));
        if (p < 85) return THRESH_W'($urandom);
        if (p < 92) return THRESH_W'($urandom_range(2040, 2060));
        return '1;
    endfunction

    // energy loads lean toward the rails to hit saturation
    function automatic logic signed [ENERGY_BITS-1:0] pick_energy();
        case ($urandom_range(0, 3))
            0:       return ENERGY_BITS'(E_MAX - $urandom_range(0, 4000));
            1:       return ENERGY_BITS'(-E_MAX - 1 + $urandom_range(0, 4000));
            default: return ENERGY_BITS'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what);
        if (mismatches < 100)
            $display("ERROR: result %0d: %s", outcomes_seen, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int p;

        // Fill pass: every bond and every spin of both layers gets written
        // before any trial, so no trial ever reads an unwritten entry.
        for (int r = 0; r < SIDE; r++)
            for (int c = 0; c < SIDE; c++)
                push_bonds(r, c, $urandom, $urandom);
        for (int r = 0; r < SIDE; r++)
            for (int c = 0; c < SIDE; c++)
                if (r < SIDE / 2)
                begin
                    push_spin(0, r, c, $urandom);
                    push_spin(1, r, c, $urandom);
                end
                else
                    push_spin($urandom_range(0, 1), r, c, $urandom);

        // Directed: site (5,3) in a shared row with all four bonds at -128
        // and all spins +1 gives dE = +2048, which saturates the 12-bit
        // field; the flip back gives -2048. Spins loaded through either
        // layer land in both.
        push_energy(E_MAX);
        push_bonds(4, 3, -128, 127);
        push_bonds(5, 3, -128, -128);
        push_bonds(5, 2, 127, -128);
        push_spin(1, 4, 3, 1);
        push_spin(0, 6, 3, 1);
        push_spin(1, 5, 2, 1);
        push_spin(0, 5, 4, 1);
        push_spin(1, 5, 3, 1);
        push_trial(0, 5, 3, 2048);      // dE equals threshold, top rail
        push_trial(1, 5, 3, 0);         // dE -2048
        push_energy(-E_MAX - 1);
        push_trial(0, 5, 3, 0);         // +2048 rejected
        push_trial(1, 5, 3, '1);        // all-ones threshold accepts it
        push_energy(-E_MAX - 1);
        push_trial(0, 5, 3, 0);         // bottom rail
        push_energy(0);
        push_trial(1, 1, 6, 20'hFFFFE); // largest threshold short of all ones
        push_trial(0, 0, 0, 0);         // wraps to row 7 and column 7
        push_trial(1, 7, 7, 0);         // shared corner, wraps to row 0

        // Random: mostly trials, with loads that keep reshaping the lattice
        for (int i = 0; i < 880; i++)
        begin
            p = $urandom_range(0, 99);
            if (p < 68)
                push_trial($urandom_range(0, 1), $urandom_range(0, SIDE - 1),
                           $urandom_range(0, SIDE - 1), pick_threshold());
            else if (p < 78)
                push_bonds($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                           $urandom, $urandom);
            else if (p < 90)
                push_spin($urandom_range(0, 1), $urandom_range(0, SIDE - 1),
                          $urandom_range(0, SIDE - 1), $urandom);
            else
                push_energy(pick_energy());
        end
        cmds_total = lattice_cmds.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmds_taken != cmds_total || due_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (mismatches == 0 && due_outcomes.size() == 0)
            $display("replica_ising_metropolis_flip_core: match");
        else
            $display("replica_ising_metropolis_flip_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: a beat is held until taken; new beats start at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && cmds_taken != cmds_offered)
            ;   // stalled beat stays on the port unchanged
        else if (lattice_cmds.size() != 0 &&
                 ((cmds_taken >= 340 && cmds_taken < 360) ||
                  (cmds_taken >= 500 && cmds_taken < 700) ||
                  $urandom_range(0, 99) >= STALL_PCT))
        begin
            // no gaps around the receiver hold-off and in the steady window
            cur_cmd = lattice_cmds.pop_front();
            cmds_offered++;
            in_valid         <= 1'b1;
            cmd              <= cur_cmd.op;
            layer            <= cur_cmd.lay;
            site_row         <= cur_cmd.row;
            site_col         <= cur_cmd.col;
            bond_down        <= cur_cmd.down;
            bond_right       <= cur_cmd.right;
            spin_up          <= cur_cmd.spin;
            energy_load      <= cur_cmd.energy;
            accept_threshold <= cur_cmd.thresh;
        end
        else
            in_valid <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Receiver stall: random, one long hold-off so the core backs up into
    // its input, and a steady window with no stalls.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_done && cmds_taken >= 350)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (cmds_taken >= 500 && cmds_taken < 700)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < STALL_PCT);
    end

    // Input beat taken: advance the lattice copy, queue the expected result
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            due_outcomes.push_back(apply_lattice_cmd(cur_cmd));
            cmds_taken++;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each result beat with the oldest expected outcome
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        flip_outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_outcomes.size() == 0)
                report_mismatch("result beat with no command outstanding");
            else
            begin
                want = due_outcomes.pop_front();
                if (accepted !== want.acc)
                    report_mismatch($sformatf("accepted %b, want %b",
                                              accepted, want.acc));
                if (energy_change !== want.de)
                    report_mismatch($sformatf("energy_change %0d, want %0d",
                                              energy_change, want.de));
                if (energy_total !== want.total)
                    report_mismatch($sformatf("energy_total %0d, want %0d",
                                              energy_total, want.total));
            end
            outcomes_seen++;
        end
    end

    // Watchdog: cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG)
        begin
            $display("ERROR: no beat for %0d cycles", WATCHDOG);
            $display("replica_ising_metropolis_flip_core: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

/* replica_ising_metropolis_flip_core.f */
hdl/rimf_pkg.sv
hdl/rimf_ctrl.sv
hdl/rimf_datapath.sv
hdl/replica_ising_metropolis_flip_core.sv
tb/sv/testbench.sv
